FILE: hdl/assert_macros.svh
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// cond holds in every cycle
`define ASSERT_ALWAYS(lbl, cond, msg) \
  `ASSERT_IMPLIES(lbl, 1'b1, cond, msg)

`endif

FILE: hdl/tbh_pkg.sv
package tbh_pkg;

  // input command codes
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_REV  = 2'd2
  } tbh_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GUESS_MUL,
    ST_GUESS_WR,
    ST_EMA_NEW,
    ST_EMA_OLD,
    ST_EMA_SAT,
    ST_ERR_MUL,
    ST_DRIVE,
    ST_MV_MUL,
    ST_OUT
  } tbh_state_t;

  // operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_GUESS,
    MUL_EMA_NEW,
    MUL_EMA_OLD,
    MUL_ERR,
    MUL_MV
  } tbh_mul_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    tbh_mul_t mul_sel;
    logic     acc_load;
    logic     filt_upd;
    logic     err_upd;
    logic     drive_upd;
    logic     guess_upd;
    logic     out_load;
    logic     out_rev;
  } tbh_cmd_t;

  typedef struct packed {
    logic rev_spin;
    logic out_free;
  } tbh_sts_t;

  // configuration register indexes
  localparam logic CFG_GAIN  = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  localparam logic [23:0] GAIN_RESET  = 24'd168;
  localparam logic [16:0] ALPHA_RESET = 17'd32768;

  localparam logic [16:0] FULL_DRIVE = 17'd65536;
  localparam logic signed [29:0] FULL_MV = 30'sd12000;
  localparam logic signed [14:0] REVERSE_MV = -15'sd12000;

  // guess = (target*65536 + 1800) / 3600 via reciprocal, exact for 28-bit dividends
  localparam int unsigned GUESS_SHIFT = 40;
  localparam logic [63:0] GUESS_RECIP_FULL = ((64'd1 << GUESS_SHIFT) + 64'd3599) / 64'd3600;
  localparam logic [29:0] GUESS_RECIP = GUESS_RECIP_FULL[29:0];
  localparam logic [27:0] GUESS_BIAS = 28'd1800;

  // rpm * 18 * 256 as signed Q.8 speed
  function automatic logic signed [22:0] scaled_m8(input logic [9:0] rpm);
    logic signed [22:0] s;
    s = $signed({{13{rpm[9]}}, rpm});
    return (s <<< 12) + (s <<< 9);
  endfunction

endpackage

FILE: hdl/tbh_ctrl.sv
`include "assert_macros.svh"

module tbh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        in_op,
  input  logic              in_pvalid,
  input  tbh_pkg::tbh_sts_t sts,
  output tbh_pkg::tbh_cmd_t cmd
);

  tbh_pkg::tbh_state_t state, state_next;
  logic rev_tick, rev_tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tbh_pkg::ST_IDLE;
      rev_tick <= 1'b0;
    end else begin
      state    <= state_next;
      rev_tick <= rev_tick_next;
    end
  end

  always_comb begin
    state_next    = state;
    rev_tick_next = rev_tick;
    cmd           = '0;
    s_tready      = 1'b0;
    unique case (state)
      tbh_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept    = 1'b1;
          rev_tick_next = 1'b0;
          case (in_op)
            tbh_pkg::OP_SET: begin
              if (!in_pvalid) state_next = tbh_pkg::ST_GUESS_MUL;
            end
            tbh_pkg::OP_TICK: begin
              rev_tick_next = sts.rev_spin;
              state_next = sts.rev_spin ? tbh_pkg::ST_OUT : tbh_pkg::ST_EMA_NEW;
            end
            default: ;
          endcase
        end
      end
      tbh_pkg::ST_GUESS_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbh_pkg::MUL_GUESS;
        state_next  = tbh_pkg::ST_GUESS_WR;
      end
      tbh_pkg::ST_GUESS_WR: begin
        cmd.guess_upd = 1'b1;
        state_next    = tbh_pkg::ST_IDLE;
      end
      tbh_pkg::ST_EMA_NEW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbh_pkg::MUL_EMA_NEW;
        state_next  = tbh_pkg::ST_EMA_OLD;
      end
      tbh_pkg::ST_EMA_OLD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = tbh_pkg::MUL_EMA_OLD;
        cmd.acc_load = 1'b1;
        state_next   = tbh_pkg::ST_EMA_SAT;
      end
      tbh_pkg::ST_EMA_SAT: begin
        cmd.filt_upd = 1'b1;
        state_next   = tbh_pkg::ST_ERR_MUL;
      end
      tbh_pkg::ST_ERR_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbh_pkg::MUL_ERR;
        cmd.err_upd = 1'b1;
        state_next  = tbh_pkg::ST_DRIVE;
      end
      tbh_pkg::ST_DRIVE: begin
        cmd.drive_upd = 1'b1;
        state_next    = tbh_pkg::ST_MV_MUL;
      end
      tbh_pkg::ST_MV_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbh_pkg::MUL_MV;
        state_next  = tbh_pkg::ST_OUT;
      end
      tbh_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_rev  = rev_tick;
          state_next   = tbh_pkg::ST_IDLE;
        end
      end
      default: state_next = tbh_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held one")
  `ASSERT_NEXT(a_tick_busy, cmd.accept && (in_op == tbh_pkg::OP_TICK), !s_tready, "tick overlapped")

endmodule

FILE: hdl/tbh_dp.sv
`include "assert_macros.svh"

module tbh_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic [1:0]        in_op,
  input  logic [11:0]       in_tgt,
  input  logic [16:0]       in_pred,
  input  logic              in_pvalid,
  input  logic [9:0]        in_rpm,
  input  tbh_pkg::tbh_cmd_t cmd,
  output tbh_pkg::tbh_sts_t sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata
);

  localparam logic signed [42:0] EMA_HI = 43'sd2097151;
  localparam logic signed [42:0] EMA_LO = -43'sd2097152;

  logic [23:0] gain;
  logic [16:0] alpha;

  logic [11:0]        target_speed;
  logic signed [21:0] filtered_speed;
  logic signed [22:0] previous_error;
  logic [16:0]        drive_now;
  logic [16:0]        drive_guess;
  logic [16:0]        drive_at_crossing;
  logic               first_crossing_pending;
  logic               reverse_spin;

  logic [9:0]         rpm_q;
  logic signed [22:0] err_q;
  logic signed [41:0] acc;
  logic signed [59:0] prod;

  logic [16:0]        a_eff;
  logic [27:0]        guess_x;
  logic signed [29:0] mul_a, mul_b;
  logic signed [22:0] err_now;
  logic signed [42:0] ema_sum, ema_rnd;
  logic signed [21:0] filt_next;
  logic signed [47:0] step, d_raw;
  logic [16:0]        d_cl;
  logic [17:0]        mean;
  logic               sign_flip;
  logic [17:0]        g_raw;
  logic [31:0]        mv_raw;
  logic [14:0]        mv;
  logic [16:0]        pred_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= tbh_pkg::GAIN_RESET;
      alpha <= tbh_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tbh_pkg::CFG_GAIN) gain <= cfg_data;
      else alpha <= cfg_data[16:0];
    end
  end

  assign a_eff   = (alpha > tbh_pkg::FULL_DRIVE) ? tbh_pkg::FULL_DRIVE : alpha;
  assign guess_x = {target_speed, 16'b0} + tbh_pkg::GUESS_BIAS;
  assign err_now = $signed({3'b000, target_speed, 8'b0}) - $signed({filtered_speed[21], filtered_speed});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      tbh_pkg::MUL_GUESS: begin
        mul_a = $signed({2'b00, guess_x});
        mul_b = $signed(tbh_pkg::GUESS_RECIP);
      end
      tbh_pkg::MUL_EMA_NEW: begin
        mul_a = $signed({13'b0, a_eff});
        mul_b = 30'(tbh_pkg::scaled_m8(rpm_q));
      end
      tbh_pkg::MUL_EMA_OLD: begin
        mul_a = $signed({13'b0, tbh_pkg::FULL_DRIVE - a_eff});
        mul_b = 30'(filtered_speed);
      end
      tbh_pkg::MUL_ERR: begin
        mul_a = 30'(err_now);
        mul_b = $signed({6'b0, gain});
      end
      tbh_pkg::MUL_MV: begin
        mul_a = $signed({13'b0, drive_now});
        mul_b = tbh_pkg::FULL_MV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.acc_load) acc <= prod[41:0];
    if (cmd.err_upd) err_q <= err_now;
    if (cmd.accept) rpm_q <= in_rpm;
  end

  // filter: round to nearest, then clamp to the 22-bit range
  assign ema_sum = $signed({acc[41], acc}) + $signed(prod[42:0]);
  assign ema_rnd = (ema_sum + 43'sd32768) >>> 16;
  always_comb begin
    if (ema_rnd > EMA_HI) filt_next = 22'sh1FFFFF;
    else if (ema_rnd < EMA_LO) filt_next = -22'sd2097152;
    else filt_next = ema_rnd[21:0];
  end

  // integral step and clamp to 0..full
  assign step  = ($signed(prod[47:0]) + 48'sd32768) >>> 16;
  assign d_raw = $signed({31'b0, drive_now}) + step;
  always_comb begin
    if (d_raw < 48'sd0) d_cl = '0;
    else if (d_raw > $signed({31'b0, tbh_pkg::FULL_DRIVE})) d_cl = tbh_pkg::FULL_DRIVE;
    else d_cl = d_raw[16:0];
  end
  assign mean  = ({1'b0, d_cl} + {1'b0, drive_at_crossing}) >> 1;
  // sign as {negative, zero}: distinct code for each of -1, 0, +1
  assign sign_flip = {err_q[22], err_q == '0} != {previous_error[22], previous_error == '0};

  assign g_raw    = prod[57:40];
  assign pred_sat = (in_pred > tbh_pkg::FULL_DRIVE) ? tbh_pkg::FULL_DRIVE : in_pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed           <= '0;
      filtered_speed         <= '0;
      previous_error         <= '0;
      drive_now              <= '0;
      drive_guess            <= '0;
      drive_at_crossing      <= '0;
      first_crossing_pending <= 1'b0;
      reverse_spin           <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (in_op)
          tbh_pkg::OP_SET: begin
            target_speed   <= in_tgt;
            previous_error <= $signed({3'b000, in_tgt, 8'b0}) - tbh_pkg::scaled_m8(in_rpm);
            first_crossing_pending <= 1'b1;
            drive_at_crossing <= '0;
            if (in_pvalid) drive_guess <= pred_sat;
          end
          tbh_pkg::OP_REV: reverse_spin <= ~reverse_spin;
          default: ;
        endcase
      end
      if (cmd.guess_upd) begin
        drive_guess <= (g_raw > {1'b0, tbh_pkg::FULL_DRIVE}) ? tbh_pkg::FULL_DRIVE : g_raw[16:0];
      end
      if (cmd.filt_upd) filtered_speed <= filt_next;
      if (cmd.drive_upd) begin
        previous_error <= err_q;
        if (sign_flip) begin
          if (first_crossing_pending) begin
            drive_now              <= drive_guess;
            drive_at_crossing      <= drive_guess;
            first_crossing_pending <= 1'b0;
          end else begin
            drive_now         <= mean[16:0];
            drive_at_crossing <= mean[16:0];
          end
        end else begin
          drive_now <= d_cl;
        end
      end
    end
  end

  // output register
  assign mv_raw = prod[31:0] + 32'd32768;
  assign mv     = cmd.out_rev ? tbh_pkg::REVERSE_MV : mv_raw[30:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {mv, drive_now};
  end

  assign sts.rev_spin = reverse_spin;
  assign sts.out_free = !m_tvalid || m_tready;

  `ASSERT_ALWAYS(a_drive_range, drive_now <= tbh_pkg::FULL_DRIVE, "drive above full")
  `ASSERT_ALWAYS(a_guess_range, drive_guess <= tbh_pkg::FULL_DRIVE, "guess above full")

endmodule

FILE: hdl/take_back_half_velocity_control_core.sv
// take-back-half flywheel speed regulator with an ema filter on the sample
// input stream (s_*): one transaction per command; set target, control tick,
//   or toggle reverse spin. only ticks produce a result transaction
// output stream (m_*): drive level and motor millivolts, one per tick
// config port: cfg_we writes cfg_data into register cfg_index
//   (0 integral gain, 1 filter alpha) in the same clock, no read-back
// a normal tick runs the ema, error, drive and mv steps before its result is
//   loaded, and the input is ready again when it returns to idle; the shared
//   30x30 multiplier is used four times per tick (two ema terms, gain, mv)
// a reverse tick goes straight to the output step, a set without a guess runs
//   the reciprocal multiply for target/3600, other sets and toggles end at once
// one command is in flight at a time; s_tready is high only when idle
// the result sits in an output register, so a new command is taken while
//   the previous result waits; if the receiver stalls and a second tick
//   finishes, that tick holds until the register frees up
// reset (rst, synchronous): state and drive cleared, gain 168, alpha 32768
module take_back_half_velocity_control_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // target_velocity[11:0], first_guess, motor_rpm, pad
  input  logic [2:0]  s_tuser,   // command[1:0], predicted_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // drive_level[16:0], voltage_mv[31:17]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  tbh_pkg::tbh_cmd_t cmd;
  tbh_pkg::tbh_sts_t sts;

  // input transaction fields
  logic [1:0]  in_op;
  logic        in_pvalid;
  logic [11:0] in_tgt;
  logic [16:0] in_pred;
  logic [9:0]  in_rpm;

  assign in_op     = s_tuser[1:0];
  assign in_pvalid = s_tuser[2];
  assign in_tgt    = s_tdata[11:0];
  assign in_pred   = s_tdata[28:12];
  assign in_rpm    = s_tdata[38:29];

  // sequencer: walks each command through the multiplier steps
  tbh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_op     (in_op),
    .in_pvalid (in_pvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // regulator state, shared multiplier and output register
  tbh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (in_op),
    .in_tgt    (in_tgt),
    .in_pred   (in_pred),
    .in_pvalid (in_pvalid),
    .in_rpm    (in_rpm),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
